### rtl/core/rtccal_pkg.sv
`default_nettype none

package rtccal_pkg;

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_SET    = 1'b1
    } op_t;

    // date and time loaded by a set request
    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  millis;
    } set_fields_t;

    localparam logic [6:0] SEC_PER_MIN  = 7'd60;
    localparam logic [6:0] MIN_PER_HOUR = 7'd60;
    localparam logic [5:0] HOUR_PER_DAY = 6'd24;
    localparam logic [2:0] DAYS_PER_WEEK = 3'd7;
    localparam logic [9:0] MILLIS_PER_SEC = 10'd1000;
    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_DEC = 4'd12;
    localparam logic [15:0] YEAR_MAX = 16'hFFFF;

    // year mod 25 by reciprocal: q = (year * ceil(2^21 / 25)) >> 21, exact for 16-bit years
    localparam int          YEAR_RECIP_SHIFT = 21;
    localparam int          YEAR_Q_W         = 12;
    localparam int          YEAR_PROD_W      = YEAR_RECIP_SHIFT + YEAR_Q_W;
    localparam logic [16:0] YEAR_RECIP       = 17'd83887;
    localparam logic [4:0]  YEAR_MOD_LAST    = 5'd24;

    function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

### rtl/core/rtccal_split.sv
`default_nettype none

module rtccal_split #(
    parameter int TICKS_PER_SECOND_LOG2 = 15,
    localparam int FW = TICKS_PER_SECOND_LOG2,
    localparam int SW = 32 - TICKS_PER_SECOND_LOG2,
    localparam int DW = (SW > 17) ? SW - 16 : 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      operation,
    input  logic [31:0]               counter_value,
    input  rtccal_pkg::set_fields_t   set_in,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      out_op,
    output logic [FW-1:0]             out_frac,
    output logic [5:0]                out_d_sec,
    output logic [5:0]                out_d_min,
    output logic [4:0]                out_d_hour,
    output logic [DW-1:0]             out_d_day,
    output rtccal_pkg::set_fields_t   out_set,
    output logic [4:0]                out_year_mod
);

    // quotient widths: secs/60, secs/3600, secs/86400
    localparam int Q1W = SW - 5;
    localparam int Q2W = (SW > 12) ? SW - 11 : 1;

    // exact reciprocals: k = input width + ceil(log2 d), m = ceil(2^k / d)
    localparam int K1 = SW + 6;
    localparam int K2 = Q1W + 6;
    localparam int K3 = Q2W + 5;
    localparam longint unsigned M1_FULL = ((64'd1 << K1) + 64'd59) / 64'd60;
    localparam longint unsigned M2_FULL = ((64'd1 << K2) + 64'd59) / 64'd60;
    localparam longint unsigned M3_FULL = ((64'd1 << K3) + 64'd23) / 64'd24;
    localparam logic [SW:0]  M1 = M1_FULL[SW:0];
    localparam logic [Q1W:0] M2 = M2_FULL[Q1W:0];
    localparam logic [Q2W:0] M3 = M3_FULL[Q2W:0];
    localparam int P1W = K1 + Q1W;
    localparam int P2W = K2 + Q2W;
    localparam int P3W = K3 + DW;

    logic [31:0] last_reading_reg;

    logic v_a_reg, v_b_reg, v_c_reg, v_d_reg, v_e_reg;
    logic en_a, en_b, en_c, en_d, en_e;

    // stage a: gap since last reading
    logic                    a_op_reg;
    logic [31:0]             a_gap_reg;
    logic [31:0]             a_gap_next;
    rtccal_pkg::set_fields_t a_set_reg;

    // stage b: seconds / 60, year / 25
    logic                             b_op_reg;
    logic [SW-1:0]                    b_secs_reg;
    logic [FW-1:0]                    b_frac_reg;
    logic [Q1W-1:0]                   b_q60_reg;
    logic [Q1W-1:0]                   b_q60_next;
    logic [rtccal_pkg::YEAR_Q_W-1:0]  b_yq_reg;
    logic [rtccal_pkg::YEAR_Q_W-1:0]  b_yq_next;
    rtccal_pkg::set_fields_t          b_set_reg;
    logic [P1W-1:0]                   prod1;
    logic [rtccal_pkg::YEAR_PROD_W-1:0] prod_year;

    // stage c: second delta, minutes / 60, year mod 25
    logic                    c_op_reg;
    logic [FW-1:0]           c_frac_reg;
    logic [5:0]              c_d_sec_reg;
    logic [5:0]              c_d_sec_next;
    logic [Q1W-1:0]          c_q60_reg;
    logic [Q2W-1:0]          c_q3600_reg;
    logic [Q2W-1:0]          c_q3600_next;
    logic [4:0]              c_ymod_reg;
    logic [4:0]              c_ymod_next;
    rtccal_pkg::set_fields_t c_set_reg;
    logic [P2W-1:0]          prod2;
    logic [SW-1:0]           q60_ext;
    logic [SW-1:0]           q60_times60;
    logic [15:0]             yq_ext;

    // stage d: minute delta, hours / 24
    logic                    d_op_reg;
    logic [FW-1:0]           d_frac_reg;
    logic [5:0]              d_d_sec_reg;
    logic [5:0]              d_d_min_reg;
    logic [5:0]              d_d_min_next;
    logic [Q2W-1:0]          d_q3600_reg;
    logic [DW-1:0]           d_qd_reg;
    logic [DW-1:0]           d_qd_next;
    logic [4:0]              d_ymod_reg;
    rtccal_pkg::set_fields_t d_set_reg;
    logic [P3W-1:0]          prod3;
    logic [Q1W-1:0]          q3600_ext;
    logic [Q1W-1:0]          q3600_times60;

    // stage e: hour delta and whole days
    logic                    e_op_reg;
    logic [FW-1:0]           e_frac_reg;
    logic [5:0]              e_d_sec_reg;
    logic [5:0]              e_d_min_reg;
    logic [4:0]              e_d_hour_reg;
    logic [4:0]              e_d_hour_next;
    logic [DW-1:0]           e_d_day_reg;
    logic [4:0]              e_ymod_reg;
    rtccal_pkg::set_fields_t e_set_reg;
    logic [Q2W-1:0]          qd_ext;
    logic [Q2W-1:0]          hour_rem;

    assign en_e     = !v_e_reg || out_ready;
    assign en_d     = !v_d_reg || en_e;
    assign en_c     = !v_c_reg || en_d;
    assign en_b     = !v_b_reg || en_c;
    assign en_a     = !v_a_reg || en_b;
    assign in_ready = en_a;

    always_comb begin
        a_gap_next = counter_value - last_reading_reg;

        prod1      = P1W'(a_gap_reg[31:FW]) * P1W'(M1);
        b_q60_next = prod1[K1 +: Q1W];
        prod_year  = rtccal_pkg::YEAR_PROD_W'(a_set_reg.year)
                   * rtccal_pkg::YEAR_PROD_W'(rtccal_pkg::YEAR_RECIP);
        b_yq_next  = prod_year[rtccal_pkg::YEAR_RECIP_SHIFT +: rtccal_pkg::YEAR_Q_W];

        q60_ext      = SW'(b_q60_reg);
        q60_times60  = (q60_ext << 6) - (q60_ext << 2);
        c_d_sec_next = 6'(b_secs_reg - q60_times60);
        prod2        = P2W'(b_q60_reg) * P2W'(M2);
        c_q3600_next = prod2[K2 +: Q2W];
        yq_ext       = 16'(b_yq_reg);
        c_ymod_next  = 5'(b_set_reg.year - ((yq_ext << 4) + (yq_ext << 3) + yq_ext));

        q3600_ext     = Q1W'(c_q3600_reg);
        q3600_times60 = (q3600_ext << 6) - (q3600_ext << 2);
        d_d_min_next  = 6'(c_q60_reg - q3600_times60);
        prod3         = P3W'(c_q3600_reg) * P3W'(M3);
        d_qd_next     = prod3[K3 +: DW];

        qd_ext        = Q2W'(d_qd_reg);
        hour_rem      = d_q3600_reg - ((qd_ext << 4) + (qd_ext << 3));
        e_d_hour_next = 5'(hour_rem);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_a_reg          <= 1'b0;
            v_b_reg          <= 1'b0;
            v_c_reg          <= 1'b0;
            v_d_reg          <= 1'b0;
            v_e_reg          <= 1'b0;
            last_reading_reg <= 32'd0;
        end else begin
            if (en_a) begin
                v_a_reg <= in_valid;
            end
            if (en_b) begin
                v_b_reg <= v_a_reg;
            end
            if (en_c) begin
                v_c_reg <= v_b_reg;
            end
            if (en_d) begin
                v_d_reg <= v_c_reg;
            end
            if (en_e) begin
                v_e_reg <= v_d_reg;
            end
            if (in_valid && en_a) begin
                last_reading_reg <= counter_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && en_a) begin
            a_op_reg  <= operation;
            a_gap_reg <= a_gap_next;
            a_set_reg <= set_in;
        end
        if (v_a_reg && en_b) begin
            b_op_reg   <= a_op_reg;
            b_secs_reg <= a_gap_reg[31:FW];
            b_frac_reg <= a_gap_reg[FW-1:0];
            b_q60_reg  <= b_q60_next;
            b_yq_reg   <= b_yq_next;
            b_set_reg  <= a_set_reg;
        end
        if (v_b_reg && en_c) begin
            c_op_reg    <= b_op_reg;
            c_frac_reg  <= b_frac_reg;
            c_d_sec_reg <= c_d_sec_next;
            c_q60_reg   <= b_q60_reg;
            c_q3600_reg <= c_q3600_next;
            c_ymod_reg  <= c_ymod_next;
            c_set_reg   <= b_set_reg;
        end
        if (v_c_reg && en_d) begin
            d_op_reg    <= c_op_reg;
            d_frac_reg  <= c_frac_reg;
            d_d_sec_reg <= c_d_sec_reg;
            d_d_min_reg <= d_d_min_next;
            d_q3600_reg <= c_q3600_reg;
            d_qd_reg    <= d_qd_next;
            d_ymod_reg  <= c_ymod_reg;
            d_set_reg   <= c_set_reg;
        end
        if (v_d_reg && en_e) begin
            e_op_reg     <= d_op_reg;
            e_frac_reg   <= d_frac_reg;
            e_d_sec_reg  <= d_d_sec_reg;
            e_d_min_reg  <= d_d_min_reg;
            e_d_hour_reg <= e_d_hour_next;
            e_d_day_reg  <= d_qd_reg;
            e_ymod_reg   <= d_ymod_reg;
            e_set_reg    <= d_set_reg;
        end
    end

    assign out_valid    = v_e_reg;
    assign out_op       = e_op_reg;
    assign out_frac     = e_frac_reg;
    assign out_d_sec    = e_d_sec_reg;
    assign out_d_min    = e_d_min_reg;
    assign out_d_hour   = e_d_hour_reg;
    assign out_d_day    = e_d_day_reg;
    assign out_set      = e_set_reg;
    assign out_year_mod = e_ymod_reg;

endmodule

`default_nettype wire

### rtl/core/rtccal_calendar.sv
`default_nettype none

module rtccal_calendar #(
    parameter int TICKS_PER_SECOND_LOG2 = 15,
    localparam int FW = TICKS_PER_SECOND_LOG2,
    localparam int SW = 32 - TICKS_PER_SECOND_LOG2,
    localparam int DW = (SW > 17) ? SW - 16 : 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    op,
    input  logic [FW-1:0]           frac_gap,
    input  logic [5:0]              d_sec,
    input  logic [5:0]              d_min,
    input  logic [4:0]              d_hour,
    input  logic [DW-1:0]           d_day,
    input  rtccal_pkg::set_fields_t set_in,
    input  logic [4:0]              set_year_mod,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [15:0]             year_out,
    output logic [3:0]              month_out,
    output logic [4:0]              day_out,
    output logic [2:0]              weekday_out,
    output logic [4:0]              hour_out,
    output logic [5:0]              minute_out,
    output logic [5:0]              second_out,
    output logic [9:0]              millis_out
);

    // day and weekday sums hold the old value, a carry and up to 2^DW - 1 days
    localparam int CW = ((DW > 5) ? DW : 5) + 2;

    logic            out_valid_reg;
    logic [FW-1:0]   tick_fraction_reg;
    logic [15:0]     year_reg;
    logic [4:0]      year_mod_reg;
    logic [3:0]      month_reg;
    logic [4:0]      day_reg;
    logic [2:0]      weekday_reg;
    logic [4:0]      hour_reg;
    logic [5:0]      minute_reg;
    logic [5:0]      second_reg;
    logic [9:0]      millis_reg;

    logic [FW-1:0]   tick_fraction_next;
    logic [15:0]     year_next;
    logic [4:0]      year_mod_next;
    logic [3:0]      month_next;
    logic [4:0]      day_next;
    logic [2:0]      weekday_next;
    logic [4:0]      hour_next;
    logic [5:0]      minute_next;
    logic [5:0]      second_next;
    logic [9:0]      millis_next;

    logic            step;
    logic [FW:0]     frac_sum;
    logic [FW+9:0]   millis_prod;
    logic [6:0]      sec_sum;
    logic [6:0]      sec_fix;
    logic            sec_carry;
    logic [6:0]      min_sum;
    logic [6:0]      min_fix;
    logic            min_carry;
    logic [5:0]      hour_sum;
    logic [5:0]      hour_fix;
    logic            hour_carry;
    logic [CW-1:0]   wd_sum;
    logic [CW-1:0]   wd_fix;
    logic [CW-1:0]   day_sum;
    logic [CW-1:0]   day_fix;
    logic            leap;
    logic [4:0]      mlen;
    logic            roll;
    logic            year_roll;

    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    always_comb begin
        frac_sum           = {1'b0, tick_fraction_reg} + {1'b0, frac_gap};
        tick_fraction_next = frac_sum[FW-1:0];
        millis_prod        = (FW + 10)'(tick_fraction_next)
                           * (FW + 10)'(rtccal_pkg::MILLIS_PER_SEC);
        millis_next        = millis_prod[FW +: 10];

        sec_sum     = 7'(second_reg) + 7'(frac_sum[FW]) + 7'(d_sec);
        sec_carry   = (sec_sum >= rtccal_pkg::SEC_PER_MIN);
        sec_fix     = sec_carry ? sec_sum - rtccal_pkg::SEC_PER_MIN : sec_sum;
        second_next = sec_fix[5:0];

        min_sum     = 7'(minute_reg) + 7'(sec_carry) + 7'(d_min);
        min_carry   = (min_sum >= rtccal_pkg::MIN_PER_HOUR);
        min_fix     = min_carry ? min_sum - rtccal_pkg::MIN_PER_HOUR : min_sum;
        minute_next = min_fix[5:0];

        hour_sum    = 6'(hour_reg) + 6'(min_carry) + 6'(d_hour);
        hour_carry  = (hour_sum >= rtccal_pkg::HOUR_PER_DAY);
        hour_fix    = hour_carry ? hour_sum - rtccal_pkg::HOUR_PER_DAY : hour_sum;
        hour_next   = hour_fix[4:0];

        // weekday reduced once only
        wd_sum       = CW'(weekday_reg) + CW'(hour_carry) + CW'(d_day);
        wd_fix       = (wd_sum > CW'(rtccal_pkg::DAYS_PER_WEEK))
                     ? wd_sum - CW'(rtccal_pkg::DAYS_PER_WEEK) : wd_sum;
        weekday_next = wd_fix[2:0];

        // gregorian: divisible by 4, and not by 100 unless by 400 (mod 16 and mod 25)
        leap = (year_reg[1:0] == 2'd0) && ((year_mod_reg != 5'd0) || (year_reg[3:0] == 4'd0));
        mlen = rtccal_pkg::month_length(month_reg, leap);

        day_sum  = CW'(day_reg) + CW'(hour_carry) + CW'(d_day);
        roll     = (mlen != 5'd0) && (day_sum > CW'(mlen));
        day_fix  = roll ? day_sum - CW'(mlen) : day_sum;
        day_next = day_fix[4:0];

        year_roll = roll && (month_reg == rtccal_pkg::MONTH_DEC);
        if (year_roll) begin
            month_next = rtccal_pkg::MONTH_JAN;
        end else if (roll) begin
            month_next = month_reg + 4'd1;
        end else begin
            month_next = month_reg;
        end
        year_next = year_roll ? year_reg + 16'd1 : year_reg;
        if (!year_roll) begin
            year_mod_next = year_mod_reg;
        end else if ((year_reg == rtccal_pkg::YEAR_MAX)
                     || (year_mod_reg == rtccal_pkg::YEAR_MOD_LAST)) begin
            year_mod_next = 5'd0;
        end else begin
            year_mod_next = year_mod_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg     <= 1'b0;
            tick_fraction_reg <= '0;
            year_reg          <= 16'd0;
            year_mod_reg      <= 5'd0;
            month_reg         <= 4'd1;
            day_reg           <= 5'd1;
            weekday_reg       <= 3'd1;
            hour_reg          <= 5'd0;
            minute_reg        <= 6'd0;
            second_reg        <= 6'd0;
            millis_reg        <= 10'd0;
        end else begin
            if (in_ready) begin
                out_valid_reg <= in_valid;
            end
            if (step && (op == rtccal_pkg::OP_SET)) begin
                year_reg     <= set_in.year;
                year_mod_reg <= set_year_mod;
                month_reg    <= set_in.month;
                day_reg      <= set_in.day;
                weekday_reg  <= set_in.weekday;
                hour_reg     <= set_in.hour;
                minute_reg   <= set_in.minute;
                second_reg   <= set_in.second;
                millis_reg   <= set_in.millis;
            end else if (step) begin
                tick_fraction_reg <= tick_fraction_next;
                year_reg          <= year_next;
                year_mod_reg      <= year_mod_next;
                month_reg         <= month_next;
                day_reg           <= day_next;
                weekday_reg       <= weekday_next;
                hour_reg          <= hour_next;
                minute_reg        <= minute_next;
                second_reg        <= second_next;
                millis_reg        <= millis_next;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign year_out    = year_reg;
    assign month_out   = month_reg;
    assign day_out     = day_reg;
    assign weekday_out = weekday_reg;
    assign hour_out    = hour_reg;
    assign minute_out  = minute_reg;
    assign second_out  = second_reg;
    assign millis_out  = millis_reg;

    // a good time of day stays good across an update: catches a bad delta split
    a_time_stays_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (op == rtccal_pkg::OP_UPDATE) && (second_reg < 6'd60)
            && (minute_reg < 6'd60) && (hour_reg < 5'd24)
        |=> (second_reg < 6'd60) && (minute_reg < 6'd60) && (hour_reg < 5'd24))
        else $error("time of day left its range after an update");

    a_millis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (op == rtccal_pkg::OP_UPDATE) |=> (millis_reg < 10'd1000))
        else $error("millis out of range after an update");

    a_set_keeps_fraction: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (op == rtccal_pkg::OP_SET) |=> $stable(tick_fraction_reg))
        else $error("set request changed the tick fraction");

    a_held_while_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_ready
        |=> $stable({year_reg, month_reg, day_reg, weekday_reg, tick_fraction_reg}))
        else $error("calendar moved while a result was waiting");

    a_month_roll_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (op == rtccal_pkg::OP_UPDATE) && (month_reg >= 4'd1) && (month_reg <= 4'd12)
        |=> (month_reg >= 4'd1) && (month_reg <= 4'd12))
        else $error("month rollover produced an invalid month");

endmodule

`default_nettype wire

### rtl/core/rtc_tick_calendar_update_top.sv
`default_nettype none

// calendar clock driven by a free-running 32-bit tick counter at
// 2^TICKS_PER_SECOND_LOG2 ticks per second. each request carries a counter reading;
// a set request loads date, time and millis and records the reading, an update
// request adds the elapsed time (counter difference mod 2^32) to the calendar with
// one carry per unit and at most one month rollover (gregorian leap rule). every
// request returns one result: the date and time after it. a set leaves the
// sub-second tick fraction alone; millis on update come from that fraction.
// throughput is one request per clock while m_ready takes each result: the
// elapsed-time split into days, hours, minutes and seconds runs in a pipeline of
// constant-reciprocal multipliers that does not depend on the calendar, and only the
// carry and rollover step closes a loop on the calendar registers. a request
// passes split stages a to e and then the calendar registers, which are the
// result register, so they freeze while m_valid waits on m_ready; earlier pipeline
// stages keep filling, so requests are still taken until the pipeline is full. no
// clearing pass after reset: the block is ready on the first cycle out of reset.

module rtc_tick_calendar_update_top #(
    parameter int TICKS_PER_SECOND_LOG2 = 15
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [31:0] s_counter_value,
    input  logic [15:0] s_new_year,
    input  logic [3:0]  s_new_month,
    input  logic [4:0]  s_new_day,
    input  logic [2:0]  s_new_weekday,
    input  logic [4:0]  s_new_hour,
    input  logic [5:0]  s_new_minute,
    input  logic [5:0]  s_new_second,
    input  logic [9:0]  s_new_millis,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_year_out,
    output logic [3:0]  m_month_out,
    output logic [4:0]  m_day_out,
    output logic [2:0]  m_weekday_out,
    output logic [4:0]  m_hour_out,
    output logic [5:0]  m_minute_out,
    output logic [5:0]  m_second_out,
    output logic [9:0]  m_millis_out
);

    localparam int FW = TICKS_PER_SECOND_LOG2;
    localparam int SW = 32 - TICKS_PER_SECOND_LOG2;
    localparam int DW = (SW > 17) ? SW - 16 : 1;

    // set fields of the incoming request
    rtccal_pkg::set_fields_t set_in;

    // split pipeline to calendar update
    logic                    split_valid;
    logic                    split_ready;
    logic                    split_op;
    logic [FW-1:0]           split_frac;
    logic [5:0]              split_d_sec;
    logic [5:0]              split_d_min;
    logic [4:0]              split_d_hour;
    logic [DW-1:0]           split_d_day;
    rtccal_pkg::set_fields_t split_set;
    logic [4:0]              split_year_mod;

    always_comb begin
        set_in.year    = s_new_year;
        set_in.month   = s_new_month;
        set_in.day     = s_new_day;
        set_in.weekday = s_new_weekday;
        set_in.hour    = s_new_hour;
        set_in.minute  = s_new_minute;
        set_in.second  = s_new_second;
        set_in.millis  = s_new_millis;
    end

    // elapsed-time split: gap, then /60, /3600, /86400 remainders
    rtccal_split #(
        .TICKS_PER_SECOND_LOG2(TICKS_PER_SECOND_LOG2)
    ) u_split (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .operation     (s_operation),
        .counter_value (s_counter_value),
        .set_in        (set_in),
        .out_valid     (split_valid),
        .out_ready     (split_ready),
        .out_op        (split_op),
        .out_frac      (split_frac),
        .out_d_sec     (split_d_sec),
        .out_d_min     (split_d_min),
        .out_d_hour    (split_d_hour),
        .out_d_day     (split_d_day),
        .out_set       (split_set),
        .out_year_mod  (split_year_mod)
    );

    // calendar registers, carries and month rollover
    rtccal_calendar #(
        .TICKS_PER_SECOND_LOG2(TICKS_PER_SECOND_LOG2)
    ) u_calendar (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (split_valid),
        .in_ready     (split_ready),
        .op           (split_op),
        .frac_gap     (split_frac),
        .d_sec        (split_d_sec),
        .d_min        (split_d_min),
        .d_hour       (split_d_hour),
        .d_day        (split_d_day),
        .set_in       (split_set),
        .set_year_mod (split_year_mod),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .year_out     (m_year_out),
        .month_out    (m_month_out),
        .day_out      (m_day_out),
        .weekday_out  (m_weekday_out),
        .hour_out     (m_hour_out),
        .minute_out   (m_minute_out),
        .second_out   (m_second_out),
        .millis_out   (m_millis_out)
    );

endmodule

`default_nettype wire
